[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 1048576;
    localparam int HEADER_BYTES = 12;
    localparam int MAX_SEGMENTS = 64;

    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 20;
    localparam int BYTES_W = 21;
    localparam int NEED_W  = 22;
    localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);

    // request codes
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_RESIZE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic [SIZE_W-1:0] HDR        = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] SPLIT_MIN  = SIZE_W'(HEADER_BYTES + 8);
    localparam logic [SIZE_W-1:0] INIT_SIZE  = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

    typedef struct packed {
        logic [1:0]         req_type;
        logic [BYTES_W-1:0] req_bytes;
        logic [ADDR_W-1:0]  req_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } seg_t;

    localparam int SEG_W = $bits(seg_t);

endpackage

[rtl/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with split and coalescing over a segment table.
// ----------------------------------------------------------------------------
// The segment table lives in one RAM with a single read and a single write
// port, walked by a small sequencer, and one request is handled at a time:
// req_stall stays high until the result has been placed in the output
// register. Every table access is a read issue followed by a check, so the
// time a request takes grows with the N segments walked by the first-fit or
// address search, plus the entries moved when a split opens a slot or a
// merge closes one; a resize near a full table is the worst case, and trivial
// requests (null, zero size) go straight to the response step. After reset
// the block writes the initial free segment before it takes its first item.
module first_fit_heap_allocator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffha_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffha_pkg::rsp_t rsp
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_A_RD, S_A_CK, S_U_RD, S_U_WR, S_U_FIN, S_U_FIN2, S_A_DONE,
        S_F_RD, S_F_CK, S_R_NX, S_R_NC, S_R_PV, S_R_WR,
        S_D_RD, S_D_WR, S_RESP
    } state_t;

    typedef enum logic [2:0] {
        M_ALLOC, M_REL, M_RSZ_FIND, M_RSZ_ALLOC, M_RSZ_REL
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [ffha_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ffha_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [ffha_pkg::CNT_W-1:0]  ptr_reg, ptr_next;
    logic [1:0]                  rmk_reg, rmk_next;
    logic [ffha_pkg::NEED_W-1:0] need_reg, need_next;
    logic [ffha_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ffha_pkg::ADDR_W-1:0] na_reg, na_next;
    logic [ffha_pkg::SIZE_W-1:0] acc_reg, acc_next;
    logic                        nm_reg, nm_next;
    logic                        pm_reg, pm_next;
    ffha_pkg::seg_t              cur_reg, cur_next;
    ffha_pkg::seg_t              prev_reg, prev_next;
    ffha_pkg::rsp_t              res_reg, res_next;
    ffha_pkg::rsp_t              rsp_reg, rsp_next;
    logic                        rsp_valid_reg, rsp_valid_next;

    logic                        ram_we;
    logic [ffha_pkg::SEG_AW-1:0] ram_waddr;
    ffha_pkg::seg_t              ram_wdata;
    logic [ffha_pkg::SEG_AW-1:0] ram_raddr;
    ffha_pkg::seg_t              ram_rdata;

    ffha_ram #(
        .WIDTH (ffha_pkg::SEG_W),
        .DEPTH (ffha_pkg::MAX_SEGMENTS)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [ffha_pkg::NEED_W-1:0] req_need;
    logic                        fits;
    logic [ffha_pkg::SIZE_W-1:0] rd_rem;
    logic [ffha_pkg::ADDR_W-1:0] rd_payload;

    assign req_need   = (ffha_pkg::NEED_W'(req.req_bytes) + ffha_pkg::NEED_W'(7))
                        & ~ffha_pkg::NEED_W'(7);
    assign fits       = {2'b00, ram_rdata.size} >= need_reg;
    assign rd_rem     = ram_rdata.size - need_reg[ffha_pkg::SIZE_W-1:0];
    assign rd_payload = ram_rdata.start + ffha_pkg::HDR;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        rmk_next       = rmk_reg;
        need_next      = need_reg;
        addr_next      = addr_reg;
        na_next        = na_reg;
        acc_next       = acc_reg;
        nm_next        = nm_reg;
        pm_next        = pm_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[ffha_pkg::SEG_AW-1:0];
        ram_wdata      = cur_reg;
        ram_raddr      = idx_reg[ffha_pkg::SEG_AW-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{start: '0, size: ffha_pkg::INIT_SIZE, free: 1'b1};
                cnt_next  = ffha_pkg::CNT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    need_next = req_need;
                    addr_next = req.req_addr;
                    idx_next  = '0;
                    res_next  = '{addr: '0, status: ffha_pkg::ST_OK};
                    state_next = S_RESP;
                    unique case (req.req_type)
                        ffha_pkg::REQ_ALLOC:
                        begin
                            if (req.req_bytes != '0)
                            begin
                                mode_next  = M_ALLOC;
                                state_next = S_A_RD;
                            end
                        end
                        ffha_pkg::REQ_RELEASE:
                        begin
                            if (req.req_addr != '0)
                            begin
                                mode_next  = M_REL;
                                state_next = S_F_RD;
                            end
                        end
                        ffha_pkg::REQ_RESIZE:
                        begin
                            if (req.req_addr == '0)
                            begin
                                if (req.req_bytes != '0)
                                begin
                                    mode_next  = M_ALLOC;
                                    state_next = S_A_RD;
                                end
                            end
                            else if (req.req_bytes == '0)
                            begin
                                mode_next  = M_REL;
                                state_next = S_F_RD;
                            end
                            else
                            begin
                                mode_next  = M_RSZ_FIND;
                                state_next = S_F_RD;
                            end
                        end
                        default:
                        begin
                            res_next.status = ffha_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            // first-fit search
            S_A_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    res_next   = '{addr: '0, status: ffha_pkg::ST_OOM};
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_A_CK;
                end
            end
            S_A_CK:
            begin
                if (ram_rdata.free && fits)
                begin
                    cur_next = ram_rdata;
                    acc_next = rd_rem;
                    if (rd_rem > ffha_pkg::SPLIT_MIN &&
                        cnt_reg < ffha_pkg::CNT_W'(ffha_pkg::MAX_SEGMENTS))
                    begin
                        ptr_next   = cnt_reg;
                        state_next = S_U_RD;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata;
                        ram_wdata.free = 1'b0;
                        state_next     = S_A_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + ffha_pkg::CNT_W'(1);
                    state_next = S_A_RD;
                end
            end
            // open a slot above the chosen segment, top entry first
            S_U_RD:
            begin
                ram_raddr = ffha_pkg::SEG_AW'(ptr_reg - ffha_pkg::CNT_W'(1));
                if (ptr_reg == idx_reg + ffha_pkg::CNT_W'(1))
                begin
                    state_next = S_U_FIN;
                end
                else
                begin
                    state_next = S_U_WR;
                end
            end
            S_U_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg[ffha_pkg::SEG_AW-1:0];
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_reg - ffha_pkg::CNT_W'(1);
                state_next = S_U_RD;
            end
            S_U_FIN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ffha_pkg::SEG_AW'(idx_reg + ffha_pkg::CNT_W'(1));
                ram_wdata  = '{start: cur_reg.start + ffha_pkg::HDR
                                      + need_reg[ffha_pkg::SIZE_W-1:0],
                               size:  acc_reg - ffha_pkg::HDR,
                               free:  1'b1};
                state_next = S_U_FIN2;
            end
            S_U_FIN2:
            begin
                ram_we     = 1'b1;
                ram_wdata  = '{start: cur_reg.start,
                               size:  need_reg[ffha_pkg::SIZE_W-1:0],
                               free:  1'b0};
                cnt_next   = cnt_reg + ffha_pkg::CNT_W'(1);
                state_next = S_A_DONE;
            end
            S_A_DONE:
            begin
                if (mode_reg == M_RSZ_ALLOC)
                begin
                    na_next    = cur_reg.start + ffha_pkg::HDR;
                    mode_next  = M_RSZ_REL;
                    idx_next   = '0;
                    state_next = S_F_RD;
                end
                else
                begin
                    res_next   = '{addr: cur_reg.start + ffha_pkg::HDR,
                                   status: ffha_pkg::ST_OK};
                    state_next = S_RESP;
                end
            end
            // address search; the previous entry is kept for merging
            S_F_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    res_next   = '{addr: '0, status: ffha_pkg::ST_BAD};
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_F_CK;
                end
            end
            S_F_CK:
            begin
                if (rd_payload == addr_reg)
                begin
                    cur_next = ram_rdata;
                    acc_next = ram_rdata.size;
                    nm_next  = 1'b0;
                    pm_next  = 1'b0;
                    if (ram_rdata.free)
                    begin
                        res_next   = '{addr: '0, status: ffha_pkg::ST_BAD};
                        state_next = S_RESP;
                    end
                    else if (mode_reg == M_RSZ_FIND)
                    begin
                        if (fits)
                        begin
                            res_next   = '{addr: addr_reg, status: ffha_pkg::ST_OK};
                            state_next = S_RESP;
                        end
                        else
                        begin
                            mode_next  = M_RSZ_ALLOC;
                            idx_next   = '0;
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_R_NX;
                    end
                end
                else
                begin
                    prev_next  = ram_rdata;
                    idx_next   = idx_reg + ffha_pkg::CNT_W'(1);
                    state_next = S_F_RD;
                end
            end
            S_R_NX:
            begin
                ram_raddr = ffha_pkg::SEG_AW'(idx_reg + ffha_pkg::CNT_W'(1));
                if (idx_reg + ffha_pkg::CNT_W'(1) < cnt_reg)
                begin
                    state_next = S_R_NC;
                end
                else
                begin
                    state_next = S_R_PV;
                end
            end
            S_R_NC:
            begin
                if (ram_rdata.free)
                begin
                    acc_next = acc_reg + ffha_pkg::HDR + ram_rdata.size;
                    nm_next  = 1'b1;
                end
                state_next = S_R_PV;
            end
            S_R_PV:
            begin
                if (idx_reg != '0 && prev_reg.free)
                begin
                    acc_next = acc_reg + ffha_pkg::HDR + prev_reg.size;
                    pm_next  = 1'b1;
                end
                state_next = S_R_WR;
            end
            S_R_WR:
            begin
                ram_we = 1'b1;
                if (pm_reg)
                begin
                    ram_waddr  = ffha_pkg::SEG_AW'(idx_reg - ffha_pkg::CNT_W'(1));
                    ram_wdata  = '{start: prev_reg.start, size: acc_reg, free: 1'b1};
                    ptr_next   = idx_reg;
                    rmk_next   = nm_reg ? 2'd2 : 2'd1;
                    state_next = S_D_RD;
                end
                else
                begin
                    ram_wdata = '{start: cur_reg.start, size: acc_reg, free: 1'b1};
                    ptr_next  = idx_reg + ffha_pkg::CNT_W'(1);
                    rmk_next  = 2'd1;
                    if (nm_reg)
                    begin
                        state_next = S_D_RD;
                    end
                    else
                    begin
                        res_next   = '{addr: (mode_reg == M_RSZ_REL) ? na_reg : '0,
                                       status: ffha_pkg::ST_OK};
                        state_next = S_RESP;
                    end
                end
            end
            // close the gap left by merged entries
            S_D_RD:
            begin
                ram_raddr = ffha_pkg::SEG_AW'(ptr_reg + ffha_pkg::CNT_W'(rmk_reg));
                if (ptr_reg + ffha_pkg::CNT_W'(rmk_reg) >= cnt_reg)
                begin
                    cnt_next   = cnt_reg - ffha_pkg::CNT_W'(rmk_reg);
                    res_next   = '{addr: (mode_reg == M_RSZ_REL) ? na_reg : '0,
                                   status: ffha_pkg::ST_OK};
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_D_WR;
                end
            end
            S_D_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg[ffha_pkg::SEG_AW-1:0];
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_reg + ffha_pkg::CNT_W'(1);
                state_next = S_D_RD;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            mode_reg      <= M_ALLOC;
            cnt_reg       <= ffha_pkg::CNT_W'(1);
            idx_reg       <= '0;
            ptr_reg       <= '0;
            rmk_reg       <= '0;
            nm_reg        <= 1'b0;
            pm_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
            need_reg      <= '0;
            addr_reg      <= '0;
            na_reg        <= '0;
            acc_reg       <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            rmk_reg       <= rmk_next;
            nm_reg        <= nm_next;
            pm_reg        <= pm_next;
            rsp_valid_reg <= rsp_valid_next;
            need_reg      <= need_next;
            addr_reg      <= addr_next;
            na_reg        <= na_next;
            acc_reg       <= acc_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
        end
    end

    // table occupancy stays within bounds
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg >= ffha_pkg::CNT_W'(1) &&
        cnt_reg <= ffha_pkg::CNT_W'(ffha_pkg::MAX_SEGMENTS))
        else $error("segment count out of range");

    // the table is never written while waiting for an item
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESP) |-> !ram_we)
        else $error("table write outside a request");

    // a fresh result only comes out of the response step
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised outside response step");

    // count only changes while a request is in progress
    a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(cnt_reg) || $past(state_reg) != S_IDLE)
        else $error("segment count moved while idle");

endmodule

[rtl/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/sv/first_fit_heap_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_tb
// Self-checking bench for the first-fit heap allocator. A queue-fed driver
// offers allocate, release, resize and unknown items. A shadow segment table
// predicts each result, and a monitor checks every response against it in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int N_RANDOM    = 580;

    // request code outside the defined set
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ffha_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ffha_pkg::rsp_t rsp;

    first_fit_heap_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // shadow of the segment table
    int unsigned seg_base [ffha_pkg::MAX_SEGMENTS];
    int unsigned seg_len  [ffha_pkg::MAX_SEGMENTS];
    bit          seg_avail[ffha_pkg::MAX_SEGMENTS];
    int unsigned seg_n;

    ffha_pkg::req_t pending_reqs[$];
    ffha_pkg::rsp_t expected_rsps[$];
    int unsigned    live_addrs[$];

    int errors    = 0;
    int cycles    = 0;
    int n_checked = 0;
    int n_oom     = 0;
    int n_bad     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_n  = 0;
    int hold_seen_n = 0;
    int hold_cnt    = 0;

    task automatic mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic table_reset();
        seg_n = 1;
        seg_base[0]  = 0;
        seg_len[0]   = ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES;
        seg_avail[0] = 1'b1;
    endtask

    function automatic int seg_lookup(input int unsigned a);
        for (int i = 0; i < seg_n; i++)
            if (seg_base[i] + ffha_pkg::HEADER_BYTES == a)
                return i;
        return -1;
    endfunction

    task automatic seg_drop(input int idx);
        for (int i = idx; i + 1 < seg_n; i++)
        begin
            seg_base[i]  = seg_base[i+1];
            seg_len[i]   = seg_len[i+1];
            seg_avail[i] = seg_avail[i+1];
        end
        seg_n--;
    endtask

    task automatic heap_take(input int unsigned bytes, output int unsigned a,
                             output logic [1:0] st);
        int unsigned need;
        int unsigned rem;
        a  = 0;
        st = ffha_pkg::ST_OOM;
        if (bytes == 0)
        begin
            st = ffha_pkg::ST_OK;
            return;
        end
        need = (bytes + 7) & ~32'd7;
        for (int i = 0; i < seg_n; i++)
        begin
            if (!seg_avail[i] || seg_len[i] < need)
                continue;
            rem = seg_len[i] - need;
            // split only when the tail is worth a segment and a slot is left
            if (rem > ffha_pkg::HEADER_BYTES + 8 && seg_n < ffha_pkg::MAX_SEGMENTS)
            begin
                for (int j = seg_n; j > i + 1; j--)
                begin
                    seg_base[j]  = seg_base[j-1];
                    seg_len[j]   = seg_len[j-1];
                    seg_avail[j] = seg_avail[j-1];
                end
                seg_base[i+1]  = seg_base[i] + ffha_pkg::HEADER_BYTES + need;
                seg_len[i+1]   = rem - ffha_pkg::HEADER_BYTES;
                seg_avail[i+1] = 1'b1;
                seg_len[i]     = need;
                seg_n++;
            end
            seg_avail[i] = 1'b0;
            a  = (seg_base[i] + ffha_pkg::HEADER_BYTES) & 32'hFFFFF;
            st = ffha_pkg::ST_OK;
            return;
        end
    endtask

    task automatic heap_give(input int unsigned a, output logic [1:0] st);
        int f;
        st = ffha_pkg::ST_OK;
        if (a == 0)
            return;
        f = seg_lookup(a);
        if (f < 0 || seg_avail[f])
        begin
            st = ffha_pkg::ST_BAD;
            return;
        end
        seg_avail[f] = 1'b1;
        if (f + 1 < seg_n && seg_avail[f+1])
        begin
            seg_len[f] += ffha_pkg::HEADER_BYTES + seg_len[f+1];
            seg_drop(f + 1);
        end
        if (f > 0 && seg_avail[f-1])
        begin
            seg_len[f-1] += ffha_pkg::HEADER_BYTES + seg_len[f];
            seg_drop(f);
        end
    endtask

    task automatic live_drop(input int unsigned a);
        for (int i = 0; i < live_addrs.size(); i++)
            if (live_addrs[i] == a)
            begin
                live_addrs.delete(i);
                return;
            end
    endtask

    // works out the response to one accepted item and updates the shadow
    task automatic predict_alloc_rsp(input ffha_pkg::req_t r);
        int unsigned    a;
        int unsigned    bytes;
        int unsigned    old;
        int             f;
        logic [1:0]     st;
        ffha_pkg::rsp_t e;
        a     = 0;
        bytes = r.req_bytes;
        old   = r.req_addr;
        case (r.req_type)
            ffha_pkg::REQ_ALLOC:
            begin
                heap_take(bytes, a, st);
                if (st == ffha_pkg::ST_OK && a != 0)
                    live_addrs.push_back(a);
            end
            ffha_pkg::REQ_RELEASE:
            begin
                heap_give(old, st);
                if (st == ffha_pkg::ST_OK && old != 0)
                    live_drop(old);
            end
            ffha_pkg::REQ_RESIZE:
            begin
                if (old == 0)
                begin
                    heap_take(bytes, a, st);
                    if (st == ffha_pkg::ST_OK && a != 0)
                        live_addrs.push_back(a);
                end
                else if (bytes == 0)
                begin
                    heap_give(old, st);
                    if (st == ffha_pkg::ST_OK)
                        live_drop(old);
                end
                else
                begin
                    f = seg_lookup(old);
                    if (f < 0 || seg_avail[f])
                        st = ffha_pkg::ST_BAD;
                    else if (seg_len[f] >= ((bytes + 7) & ~32'd7))
                    begin
                        a  = old;
                        st = ffha_pkg::ST_OK;
                    end
                    else
                    begin
                        heap_take(bytes, a, st);
                        if (st == ffha_pkg::ST_OK)
                        begin
                            heap_give(old, st);
                            st = ffha_pkg::ST_OK;
                            live_drop(old);
                            live_addrs.push_back(a);
                        end
                    end
                end
            end
            default: st = ffha_pkg::ST_BAD;
        endcase
        e.addr   = a[ffha_pkg::ADDR_W-1:0];
        e.status = st;
        expected_rsps.push_back(e);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_alloc_rsp(req);
            if (!(req_valid && req_stall))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_seen_n != hold_req_n)
        begin
            hold_cnt    <= 400;
            hold_seen_n <= hold_req_n;
        end
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= (hold_cnt > 1) || ($urandom_range(99) < recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        ffha_pkg::rsp_t e;
        cycles <= cycles + 1;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
                mismatch($sformatf("unexpected response addr=%0h status=%0d",
                                   rsp.addr, rsp.status));
            else
            begin
                e = expected_rsps.pop_front();
                n_checked <= n_checked + 1;
                if (e.status == ffha_pkg::ST_OOM)
                    n_oom <= n_oom + 1;
                if (e.status == ffha_pkg::ST_BAD)
                    n_bad <= n_bad + 1;
                if (rsp.addr !== e.addr)
                    mismatch($sformatf("addr got %0h want %0h", rsp.addr, e.addr));
                if (rsp.status !== e.status)
                    mismatch($sformatf("status got %0d want %0d",
                                       rsp.status, e.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("first_fit_heap_allocator_core: mismatch");
            $finish;
        end
    end

    function automatic ffha_pkg::req_t mk(input logic [1:0] t, input int unsigned b,
                                          input int unsigned a);
        ffha_pkg::req_t r;
        r.req_type  = t;
        r.req_bytes = b[ffha_pkg::BYTES_W-1:0];
        r.req_addr  = a[ffha_pkg::ADDR_W-1:0];
        return r;
    endfunction

    function automatic int unsigned pick_live();
        if (live_addrs.size() == 0)
            return 0;
        return live_addrs[$urandom_range(live_addrs.size() - 1)];
    endfunction

    function automatic int unsigned rand_bytes();
        int k;
        k = $urandom_range(99);
        if (k < 70)
            return $urandom_range(1, 256);
        if (k < 85)
            return $urandom_range(257, 20000);
        if (k < 95)
            return $urandom_range(20001, 400000);
        return $urandom_range(400001, 2097151);
    endfunction

    function automatic ffha_pkg::req_t rand_req();
        int k;
        k = $urandom_range(99);
        // grow the table towards full, then lean towards releases
        if (live_addrs.size() > 55 && k < 45)
            k = 60;
        if (k < 45)
            return mk(ffha_pkg::REQ_ALLOC, rand_bytes(), $urandom);
        if (k < 70)
            return mk(ffha_pkg::REQ_RELEASE, $urandom, pick_live());
        if (k < 88)
            return mk(ffha_pkg::REQ_RESIZE, ($urandom_range(3) == 0) ? 0 : rand_bytes(),
                      pick_live());
        case ($urandom_range(4))
            0: return mk(REQ_UNKNOWN, $urandom, $urandom);
            1: return mk(ffha_pkg::REQ_RELEASE, $urandom, $urandom);
            2: return mk(ffha_pkg::REQ_RESIZE, $urandom, $urandom);
            3: return mk(ffha_pkg::REQ_ALLOC, 0, $urandom);
            default: return mk(ffha_pkg::REQ_RESIZE, $urandom_range(1, 64), 0);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        table_reset();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners and special cases from a fresh heap
        pending_reqs.push_back(mk(ffha_pkg::REQ_ALLOC, 0, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_ALLOC, 1, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_ALLOC, 8, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RELEASE, 0, 12));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RELEASE, 0, 12));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RELEASE, 0, 5));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RELEASE, 2097151, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RELEASE, 0, 20'hFFFFF));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 16, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 0, 32));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 4, 52));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 100, 52));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 8, 12));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 8, 7));
        pending_reqs.push_back(mk(ffha_pkg::REQ_ALLOC, 1048576, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_ALLOC, 2097151, 0));
        pending_reqs.push_back(mk(REQ_UNKNOWN, 2097151, 20'hFFFFF));
        pending_reqs.push_back(mk(REQ_UNKNOWN, 0, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_ALLOC, 1000000, 0));
        pending_reqs.push_back(mk(ffha_pkg::REQ_RESIZE, 1048576, 12));
        wait_drained();

        // random, three idling regimes
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 67 : 0;
            recv_stall_pct = (ph == 0) ? 67 : (ph == 1) ? 32 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++)
            begin
                if (ph == 2 && n == 20)
                    hold_req_n++;
                // top up only when the driver is nearly dry, so addresses stay fresh
                while (pending_reqs.size() > 0)
                    @(posedge clk);
                pending_reqs.push_back(rand_req());
                if (ph == 2 && n >= 20 && n < 30)
                    pending_reqs.push_back(rand_req());
            end
        end
        wait_drained();
        repeat (500) @(posedge clk);

        $display("checked %0d responses (%0d out of memory, %0d bad address)",
                 n_checked, n_oom, n_bad);
        $display("segments in use at end: %0d, live blocks: %0d",
                 seg_n, live_addrs.size());
        if (errors == 0)
            $display("first_fit_heap_allocator_core: match");
        else
            $display("first_fit_heap_allocator_core: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_core.sv
tb/sv/first_fit_heap_allocator_core_tb.sv
